@@ src/segment_crossing_checker_unit_assert.svh @@
// assertion macros for the segment crossing checker
// used by the checker top level; needs clk and rst in scope
`ifndef SEGMENT_CROSSING_CHECKER_UNIT_ASSERT_SVH
`define SEGMENT_CROSSING_CHECKER_UNIT_ASSERT_SVH

// implication checked at every clock edge outside reset
`define SCC_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// property that must hold in the cycle after the condition
`define SCC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ src/scc_pkg.sv @@
// shared types and constants for the segment crossing checker
// no dependencies
`default_nettype none
package scc_pkg;
  localparam int unsigned CoordW = 16;
  localparam int unsigned TolW   = 20;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_ALL   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_QUERY = 2'd2
  } status_t;

  // orientation codes
  typedef enum logic [1:0] {
    OR_COL = 2'd0,
    OR_CW  = 2'd1,
    OR_CCW = 2'd2
  } orient_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_TEST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
  } seg_t;
endpackage
`default_nettype wire

@@ src/scc_pair_unit.sv @@
// shared pair test: four orientations in turn, one cross product each
// depends on scc_pkg
`default_nettype none
module scc_pair_unit
  import scc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire seg_t              seg_a,
  input  wire seg_t              seg_b,
  input  wire logic [TolW-1:0]   tolerance,
  output logic                   done,
  output logic                   crosses
);
  logic [2:0] step;
  logic       busy;
  orient_t    o [4];
  seg_t       a_r, b_r;

  logic signed [CoordW:0] dy1, dx1, dx2, dy2;
  logic signed [CoordW-1:0] px, py, qx, qy, rx, ry;
  logic signed [2*CoordW+2:0] prod1, prod2, v;
  logic [2*CoordW+2:0] mag;
  orient_t o_cur;

  // pick triple for the current orientation
  always_comb begin
    unique case (step[1:0])
      2'd0: begin px = a_r.sx; py = a_r.sy; qx = a_r.ex; qy = a_r.ey;
              rx = b_r.sx; ry = b_r.sy; end
      2'd1: begin px = a_r.sx; py = a_r.sy; qx = a_r.ex; qy = a_r.ey;
              rx = b_r.ex; ry = b_r.ey; end
      2'd2: begin px = b_r.sx; py = b_r.sy; qx = b_r.ex; qy = b_r.ey;
              rx = a_r.sx; ry = a_r.sy; end
      default: begin px = b_r.sx; py = b_r.sy; qx = b_r.ex; qy = b_r.ey;
              rx = a_r.ex; ry = a_r.ey; end
    endcase
    dy1 = {qy[CoordW-1], qy} - {py[CoordW-1], py};
    dx1 = {rx[CoordW-1], rx} - {qx[CoordW-1], qx};
    dx2 = {qx[CoordW-1], qx} - {px[CoordW-1], px};
    dy2 = {ry[CoordW-1], ry} - {qy[CoordW-1], qy};
    prod1 = (2*CoordW+3)'(dy1 * dx1);
    prod2 = (2*CoordW+3)'(dx2 * dy2);
    v = prod1 - prod2;
    mag = v[2*CoordW+2] ? (2*CoordW+3)'(-v) : v;
    if (mag <= (2*CoordW+3)'(tolerance)) o_cur = OR_COL;
    else if (v > 0) o_cur = OR_CW;
    else o_cur = OR_CCW;
  end

  function automatic logic on_box(input logic signed [CoordW-1:0] ax, ay, px_, py_, bx, by);
    logic signed [CoordW-1:0] lox, hix, loy, hiy;
    lox = (ax < bx) ? ax : bx; hix = (ax < bx) ? bx : ax;
    loy = (ay < by) ? ay : by; hiy = (ay < by) ? by : ay;
    return px_ >= lox && px_ <= hix && py_ >= loy && py_ <= hiy;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        o[step[1:0]] <= o_cur;
        step <= step + 3'd1;
        if (step == 3'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= seg_a;
      b_r <= seg_b;
    end
  end

  always_comb begin
    crosses = ((o[0] != o[1]) && (o[2] != o[3]))
      || (o[0] == OR_COL && on_box(a_r.sx, a_r.sy, b_r.sx, b_r.sy, a_r.ex, a_r.ey))
      || (o[1] == OR_COL && on_box(a_r.sx, a_r.sy, b_r.ex, b_r.ey, a_r.ex, a_r.ey))
      || (o[2] == OR_COL && on_box(b_r.sx, b_r.sy, a_r.sx, a_r.sy, b_r.ex, b_r.ey))
      || (o[3] == OR_COL && on_box(b_r.sx, b_r.sy, a_r.ex, a_r.ey, b_r.ex, b_r.ey));
  end
endmodule
`default_nettype wire

@@ src/segment_crossing_checker_unit.sv @@
// segment crossing checker
// single stream item in (tdata fields from lowest: cmd, start_x, start_y,
// end_x, end_y, query_index), one result out per item. the user must write
// collinear_tolerance through cfg_we/cfg_wdata while idle, unenforced here.
// results: add, clear and a rejected or empty check give their result the
// cycle after acceptance; a single-segment check tests each stored segment
// in turn (table read, four cross products in the shared pair unit, a
// decision in S_TEST); the all-pairs check tests every ordered pair of
// stored segments in turn. the walk stops at the first crossing pair.
// one item is in flight at a time: s_tready drops from acceptance until the
// result is taken and rises the cycle after. a stalled receiver holds the
// result steady in its register. reset empties the table and clears
// tolerance; no clearing pass.
// depends on scc_pkg, scc_pair_unit, segment_crossing_checker_unit_assert.svh
`default_nettype none
`include "segment_crossing_checker_unit_assert.svh"
module segment_crossing_checker_unit
  import scc_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // cmd[1:0], start_x[17:2], start_y[33:18], end_x[49:34], end_y[65:50],
  // query_index[71:66]
  input  wire logic [71:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0], crossing_found[2], first_segment[8:3], second_segment[14:9],
  // segment_count[21:15]
  output logic [23:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata
);
  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1);

  seg_t mem [MAX_SEGMENTS];
  seg_t rd_a, rd_b;

  state_t state, state_next;
  logic [TolW-1:0] tolerance;
  logic [NW-1:0] count;
  logic [NW-1:0] ii, jj;
  logic all_mode;
  logic pair_start, pair_done, pair_cross;
  logic rd_phase;

  cmd_t cmd;
  logic [IdxW-1:0] qidx;
  seg_t in_seg;
  logic bad_query;
  assign cmd = cmd_t'(s_tdata[1:0]);
  assign in_seg = '{sx: s_tdata[17:2], sy: s_tdata[33:18],
                    ex: s_tdata[49:34], ey: s_tdata[65:50]};
  assign qidx = s_tdata[71:66];
  assign bad_query = (32'(qidx) >= 32'(count));

  logic [1:0] r_status;
  logic r_found;
  logic [IdxW-1:0] r_first, r_second;

  assign s_tready = (state == S_IDLE);
  assign m_tdata = {2'b0, CountW'(count), r_second, r_first, r_found, r_status};

  logic accept;
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) tolerance <= '0;
    else if (cfg_we) tolerance <= cfg_wdata;
  end

  // memory port: write on add, two registered reads
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_ADD && count < NW'(MAX_SEGMENTS))
      mem[count[AW-1:0]] <= in_seg;
    rd_a <= mem[ii[AW-1:0]];
    rd_b <= mem[jj[AW-1:0]];
  end

  scc_pair_unit u_pair (
    .clk(clk), .rst(rst), .start(pair_start), .seg_a(rd_a), .seg_b(rd_b),
    .tolerance(tolerance), .done(pair_done), .crosses(pair_cross)
  );

  logic last_j, last_i;
  assign last_j = (jj + NW'(1) >= count);
  assign last_i = (ii + NW'(1) >= count);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_CHECK || cmd == CMD_ALL)) begin
          if (cmd == CMD_CHECK && bad_query) state_next = S_DONE;
          else if (count == '0) state_next = S_DONE;
          else state_next = S_READ;
        end else if (accept) state_next = S_DONE;
      end
      S_READ: if (rd_phase) state_next = S_TEST;
      S_TEST: begin
        if (pair_done) begin
          if (pair_cross && ii != jj) state_next = S_DONE;
          else if (last_j && (!all_mode || last_i)) state_next = S_DONE;
          else state_next = S_READ;
        end
      end
      S_DONE: if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid = (state == S_DONE);
    pair_start = (state == S_READ) && rd_phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_phase <= 1'b0;
    end else begin
      state <= state_next;
      rd_phase <= (state == S_READ) && !rd_phase;
      if (accept && cmd == CMD_ADD && count < NW'(MAX_SEGMENTS)) count <= count + NW'(1);
      if (accept && cmd == CMD_CLEAR) count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_status <= ST_OK; r_found <= 1'b0; r_first <= '0; r_second <= '0;
      all_mode <= (cmd == CMD_ALL);
      jj <= '0;
      ii <= (cmd == CMD_CHECK) ? NW'(qidx) : '0;
      if (cmd == CMD_ADD) begin
        if (count >= NW'(MAX_SEGMENTS)) r_status <= ST_FULL;
        else r_first <= IdxW'(count);
      end else if (cmd == CMD_CHECK && bad_query) r_status <= ST_BAD_QUERY;
    end else if (state == S_TEST && pair_done) begin
      if (pair_cross && ii != jj) begin
        r_found <= 1'b1; r_first <= IdxW'(ii); r_second <= IdxW'(jj);
      end else if (last_j) begin
        jj <= '0;
        ii <= ii + NW'(1);
      end else jj <= jj + NW'(1);
    end
  end

  `SCC_ASSERT_IMP(a_ready_idle, s_tready, state == S_IDLE, "ready outside idle")
  `SCC_ASSERT_IMP(a_count_max, 1'b1, count <= NW'(MAX_SEGMENTS), "count overflow")
  `SCC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `SCC_ASSERT_IMP(a_found_pair, m_tvalid && r_found, r_first != r_second, "self pair reported")
endmodule
`default_nettype wire
